FILE: rtl/core/vbvt_pkg.sv
`default_nettype none
package vbvt_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegViewMinX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegViewMinY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegViewW     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegViewH     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAlign     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSlice     = 3'd5;

  typedef enum logic [1:0] {
    POS_MIN = 2'd0,
    POS_MID = 2'd1,
    POS_MAX = 2'd2
  } pos_e;

  typedef struct packed {
    logic en;
    pos_e xpos;
    pos_e ypos;
  } align_t;

  typedef struct packed {
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic [30:0]        box_width;
    logic [30:0]        box_height;
  } box_t;

  typedef struct packed {
    logic [31:0]        scale_horizontal;
    logic [31:0]        scale_vertical;
    logic signed [31:0] offset_horizontal;
    logic signed [31:0] offset_vertical;
  } xform_t;

  function automatic align_t decode_align(input logic [3:0] code);
    align_t a;
    a = '{en: 1'b1, xpos: POS_MIN, ypos: POS_MIN};
    case (code)
      4'd1: a = '{en: 1'b1, xpos: POS_MIN, ypos: POS_MIN};
      4'd2: a = '{en: 1'b1, xpos: POS_MID, ypos: POS_MIN};
      4'd3: a = '{en: 1'b1, xpos: POS_MAX, ypos: POS_MIN};
      4'd4: a = '{en: 1'b1, xpos: POS_MIN, ypos: POS_MID};
      4'd5: a = '{en: 1'b1, xpos: POS_MID, ypos: POS_MID};
      4'd6: a = '{en: 1'b1, xpos: POS_MAX, ypos: POS_MID};
      4'd7: a = '{en: 1'b1, xpos: POS_MIN, ypos: POS_MAX};
      4'd8: a = '{en: 1'b1, xpos: POS_MID, ypos: POS_MAX};
      4'd9: a = '{en: 1'b1, xpos: POS_MAX, ypos: POS_MAX};
      default: a = '{en: 1'b0, xpos: POS_MIN, ypos: POS_MIN};
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/vbvt_if.sv
`default_nettype none
interface vbvt_box_if;
  logic            valid;
  logic            ready;
  vbvt_pkg::box_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vbvt_xform_if;
  logic             valid;
  logic             ready;
  vbvt_pkg::xform_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/viewbox_viewport_transform.sv
// An accepted box goes through the divider stages, then stages A to D, to the output.
// Throughput: one box per cycle; the two 32-stage restoring dividers and the
// multiply stage each take a new box every cycle.
// A stalled output holds the whole pipeline in place.
// Reset (rst_ni low, asynchronous) clears all valid bits and the view box
// registers to zero.
`default_nettype none
module viewbox_viewport_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [vbvt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [vbvt_pkg::CfgDataW-1:0]  cfg_data_i,
  vbvt_box_if.sink                            box_i,
  vbvt_xform_if.source                        xform_o
);

  localparam int unsigned DivLat = 33;
  localparam logic [31:0] One = 32'(1) << FRAC_BITS;

  // configuration
  logic signed [31:0] view_min_x_q, view_min_y_q;
  logic [30:0]        view_width_q, view_height_q;
  logic [3:0]         align_select_q;
  logic               slice_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_min_x_q   <= '0;
      view_min_y_q   <= '0;
      view_width_q   <= '0;
      view_height_q  <= '0;
      align_select_q <= '0;
      slice_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vbvt_pkg::RegViewMinX: view_min_x_q   <= cfg_data_i;
        vbvt_pkg::RegViewMinY: view_min_y_q   <= cfg_data_i;
        vbvt_pkg::RegViewW:    view_width_q   <= cfg_data_i[30:0];
        vbvt_pkg::RegViewH:    view_height_q  <= cfg_data_i[30:0];
        vbvt_pkg::RegAlign:    align_select_q <= cfg_data_i[3:0];
        vbvt_pkg::RegSlice:    slice_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vbvt_pkg::align_t align;
  assign align = vbvt_pkg::decode_align(align_select_q);

  logic adv;
  logic vd_q;
  assign adv = !vd_q || xform_o.ready;
  assign box_i.ready = adv;

  // divider stages: valid and box travel alongside
  logic           vdiv_q [DivLat];
  vbvt_pkg::box_t bdiv_q [DivLat];
  logic [31:0]    quo_x, quo_y;

  vbvt_div #(.FracBits(FRAC_BITS)) u_div_x (
    .clk_i, .en_i(adv), .size_i(box_i.data.box_width), .den_i(view_width_q),
    .quot_o(quo_x)
  );
  vbvt_div #(.FracBits(FRAC_BITS)) u_div_y (
    .clk_i, .en_i(adv), .size_i(box_i.data.box_height), .den_i(view_height_q),
    .quot_o(quo_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivLat; k++) vdiv_q[k] <= 1'b0;
    end else if (adv) begin
      vdiv_q[0] <= box_i.valid;
      for (int k = 1; k < DivLat; k++) vdiv_q[k] <= vdiv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bdiv_q[0] <= box_i.data;
      for (int k = 1; k < DivLat; k++) bdiv_q[k] <= bdiv_q[k-1];
    end
  end

  // stage A: meet or slice pick when aligned, else the per-axis quotients
  logic           va_q;
  vbvt_pkg::box_t ba_q;
  logic [31:0]    sa_x_q, sa_y_q;
  logic [31:0]    pick;

  assign pick = slice_enable_q ? ((quo_x > quo_y) ? quo_x : quo_y)
                               : ((quo_x < quo_y) ? quo_x : quo_y);

  // stage B: products
  logic                vb_q;
  vbvt_pkg::box_t      bb_q;
  logic [31:0]         sb_x_q, sb_y_q;
  logic signed [64:0]  pmin_x_q, pmin_y_q;
  logic [62:0]         psz_x_q, psz_y_q;

  // stage C: base translation and alignment term
  logic                vc_q;
  logic [31:0]         sc_x_q, sc_y_q;
  logic signed [65:0]  base_x_q, base_y_q, add_x_q, add_y_q;
  logic signed [65:0]  base_x_d, base_y_d, add_x_d, add_y_d;
  logic signed [65:0]  slack_x, slack_y;

  // stage D: output register
  vbvt_pkg::xform_t    xf_q;
  logic signed [65:0]  sum_x, sum_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (adv) begin
      va_q <= vdiv_q[DivLat-1];
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_comb begin
    slack_x  = 66'(signed'({1'b0, bb_q.box_width}))
             - 66'(signed'({1'b0, psz_x_q >> FRAC_BITS}));
    slack_y  = 66'(signed'({1'b0, bb_q.box_height}))
             - 66'(signed'({1'b0, psz_y_q >> FRAC_BITS}));
    base_x_d = 66'(bb_q.box_x) - 66'(pmin_x_q >>> FRAC_BITS);
    base_y_d = 66'(bb_q.box_y) - 66'(pmin_y_q >>> FRAC_BITS);
    add_x_d  = '0;
    add_y_d  = '0;
    if (align.en && view_width_q != '0) begin
      case (align.xpos)
        vbvt_pkg::POS_MID: add_x_d = slack_x >>> 1;
        vbvt_pkg::POS_MAX: add_x_d = slack_x;
        default:           add_x_d = '0;
      endcase
    end
    if (align.en && view_height_q != '0) begin
      case (align.ypos)
        vbvt_pkg::POS_MID: add_y_d = slack_y >>> 1;
        vbvt_pkg::POS_MAX: add_y_d = slack_y;
        default:           add_y_d = '0;
      endcase
    end
  end

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  assign sum_x = base_x_q + add_x_q;
  assign sum_y = base_y_q + add_y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ba_q   <= bdiv_q[DivLat-1];
      sa_x_q <= align.en ? pick : quo_x;
      sa_y_q <= align.en ? pick : quo_y;

      bb_q     <= ba_q;
      sb_x_q   <= sa_x_q;
      sb_y_q   <= sa_y_q;
      pmin_x_q <= 65'(view_min_x_q) * signed'({1'b0, sa_x_q});
      pmin_y_q <= 65'(view_min_y_q) * signed'({1'b0, sa_y_q});
      psz_x_q  <= 63'(view_width_q) * 63'(sa_x_q);
      psz_y_q  <= 63'(view_height_q) * 63'(sa_y_q);

      sc_x_q   <= sb_x_q;
      sc_y_q   <= sb_y_q;
      base_x_q <= base_x_d;
      base_y_q <= base_y_d;
      add_x_q  <= add_x_d;
      add_y_q  <= add_y_d;

      xf_q.scale_horizontal  <= sc_x_q;
      xf_q.scale_vertical    <= sc_y_q;
      xf_q.offset_horizontal <= sat32(sum_x);
      xf_q.offset_vertical   <= sat32(sum_y);
    end
  end

  assign xform_o.valid = vd_q;
  assign xform_o.data  = xf_q;

`ifndef NO_ASSERTIONS
  a_aligned_equal_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q && align.en) |->
      (xf_q.scale_horizontal == xf_q.scale_vertical))
    else $error("aligned transform with unequal scales");

  a_absent_view_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q && !align.en && view_width_q == '0) |-> (xf_q.scale_horizontal == One))
    else $error("absent view width must give unit scale");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(vc_q) && $stable(vb_q) && $stable(va_q)))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/vbvt_div.sv
`default_nettype none
module vbvt_div #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [30:0] size_i,
  input  wire logic [30:0] den_i,
  output logic      [31:0] quot_o
);

  localparam int unsigned NumW  = 31 + FracBits;
  localparam int unsigned TopW  = NumW - 32;
  localparam int unsigned ShW   = 32 - FracBits;
  localparam int unsigned Steps = 32;
  localparam logic [31:0] One   = 32'(1) << FracBits;

  logic [NumW-1:0]    num;
  logic [30:0]        rem_init;
  logic [62-FracBits:0] den_sh;
  logic               sat_init;

  logic [30:0] rem_q  [Steps+1];
  logic [31:0] low_q  [Steps+1];
  logic [31:0] quo_q  [Steps+1];
  logic [30:0] den_q  [Steps+1];
  logic        sat_q  [Steps+1];
  logic        zero_q [Steps+1];

  logic [30:0] rem_d [Steps];
  logic        bit_d [Steps];

  assign num      = {size_i, {FracBits{1'b0}}};
  assign rem_init = {{(31-TopW){1'b0}}, num[NumW-1:32]};
  assign den_sh   = {den_i, {ShW{1'b0}}};
  // quotient of 2^32 or more saturates
  assign sat_init = ({{ShW{1'b0}}, size_i} >= den_sh);

  always_comb begin
    logic [31:0] trial;
    for (int k = 0; k < Steps; k++) begin
      trial = {rem_q[k], low_q[k][Steps-1-k]};
      if (trial >= {1'b0, den_q[k]}) begin
        rem_d[k] = 31'(trial - {1'b0, den_q[k]});
        bit_d[k] = 1'b1;
      end else begin
        rem_d[k] = trial[30:0];
        bit_d[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_init;
      low_q[0]  <= num[31:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      sat_q[0]  <= sat_init;
      zero_q[0] <= (den_i == '0);
      for (int k = 0; k < Steps; k++) begin
        rem_q[k+1]  <= rem_d[k];
        low_q[k+1]  <= low_q[k];
        quo_q[k+1]  <= {quo_q[k][30:0], bit_d[k]};
        den_q[k+1]  <= den_q[k];
        sat_q[k+1]  <= sat_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  assign quot_o = zero_q[Steps] ? One : (sat_q[Steps] ? '1 : quo_q[Steps]);

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = 16;
  localparam int unsigned Latency = 37;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int HoldCycles = 300;
  localparam longint Sat32U = 64'hFFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [vbvt_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [vbvt_pkg::CfgDataW-1:0] cfg_data_i = '0;

  vbvt_box_if box_ch();
  vbvt_xform_if xform_ch();

  viewbox_viewport_transform #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .box_i(box_ch.sink), .xform_o(xform_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // predictor copy of the view box settings
  longint view_x, view_y, view_w, view_h;
  logic [3:0] align_code;
  logic slice_mode;

  vbvt_pkg::box_t box_queue[$];
  vbvt_pkg::xform_t expected_xforms[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit hold_req = 1'b0;

  function automatic longint floor_div_pow2(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint fit_scale(longint size, longint vsize);
    longint q;
    if (vsize == 0) return longint'(1) << FracBits;
    q = (size << FracBits) / vsize;
    return (q > Sat32U) ? Sat32U : q;
  endfunction

  function automatic logic [31:0] clamp_s32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [31:0] axis_shift(longint origin, longint size, longint vmin,
                                             longint vsize, longint scale, bit en,
                                             vbvt_pkg::pos_e pos);
    longint t, slack;
    t = origin - floor_div_pow2(vmin * scale, FracBits);
    if (en && vsize != 0 && pos != vbvt_pkg::POS_MIN) begin
      slack = size - floor_div_pow2(vsize * scale, FracBits);
      t += (pos == vbvt_pkg::POS_MID) ? floor_div_pow2(slack, 1) : slack;
    end
    return clamp_s32(t);
  endfunction

  function automatic vbvt_pkg::xform_t fit_box(vbvt_pkg::box_t b);
    vbvt_pkg::xform_t r;
    longint sx, sy, pick;
    bit en;
    vbvt_pkg::pos_e xp, yp;
    sx = fit_scale(longint'(b.box_width), view_w);
    sy = fit_scale(longint'(b.box_height), view_h);
    en = (align_code >= 1 && align_code <= 9);
    xp = vbvt_pkg::POS_MIN;
    yp = vbvt_pkg::POS_MIN;
    if (en) begin
      pick = slice_mode ? ((sx > sy) ? sx : sy) : ((sx < sy) ? sx : sy);
      sx = pick;
      sy = pick;
      xp = vbvt_pkg::pos_e'((align_code - 1) % 3);
      yp = vbvt_pkg::pos_e'((align_code - 1) / 3);
    end
    r.scale_horizontal = sx[31:0];
    r.scale_vertical = sy[31:0];
    r.offset_horizontal = axis_shift(longint'(b.box_x), longint'(b.box_width), view_x,
                                     view_w, sx, en, xp);
    r.offset_vertical = axis_shift(longint'(b.box_y), longint'(b.box_height), view_y,
                                   view_h, sy, en, yp);
    return r;
  endfunction

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  initial begin
    box_ch.valid = 1'b0;
    box_ch.data = '0;
    xform_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (box_ch.valid && box_ch.ready) begin
        expected_xforms.push_back(fit_box(box_ch.data));
        void'(box_queue.pop_front());
      end
      if (box_ch.valid && !box_ch.ready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        box_ch.valid <= 1'b0;
      end else if (box_queue.size() > 0) begin
        box_ch.valid <= 1'b1;
        box_ch.data <= box_queue[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(30, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        box_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern; a raised hold request starts one long hold-off
  int stall_phase = 0;
  int hold_left = 0;
  bit hold_req_q = 1'b0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    hold_req_q <= hold_req;
    if (hold_req && !hold_req_q) hold_left <= HoldCycles;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    if ((hold_req && !hold_req_q) || hold_left > 1) xform_ch.ready <= 1'b0;
    else if ((stall_phase / 200) % 2 == 0) xform_ch.ready <= 1'b1;
    else xform_ch.ready <= ($urandom_range(3, 0) != 0);
  end

  // monitor
  always @(posedge clk_i) begin
    vbvt_pkg::xform_t exp_x;
    if (rst_ni) begin
      if ((box_ch.valid && box_ch.ready) || (xform_ch.valid && xform_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (xform_ch.valid && xform_ch.ready) begin
        if (expected_xforms.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transform %h", xform_ch.data);
        end else begin
          exp_x = expected_xforms.pop_front();
          if (exp_x !== xform_ch.data) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected sx=%h sy=%h tx=%h ty=%h",
                        " got sx=%h sy=%h tx=%h ty=%h"},
                       exp_x.scale_horizontal, exp_x.scale_vertical, exp_x.offset_horizontal,
                       exp_x.offset_vertical, xform_ch.data.scale_horizontal,
                       xform_ch.data.scale_vertical, xform_ch.data.offset_horizontal,
                       xform_ch.data.offset_vertical);
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [vbvt_pkg::CfgIdxW-1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vbvt_pkg::RegViewMinX: view_x = longint'($signed(value));
      vbvt_pkg::RegViewMinY: view_y = longint'($signed(value));
      vbvt_pkg::RegViewW: view_w = longint'(value[30:0]);
      vbvt_pkg::RegViewH: view_h = longint'(value[30:0]);
      vbvt_pkg::RegAlign: align_code = value[3:0];
      vbvt_pkg::RegSlice: slice_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (box_queue.size() > 0 || box_ch.valid || expected_xforms.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_s32();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
      3: return $urandom_range(32'h0100_0000, 0) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_u31();
    case ($urandom_range(6, 0))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(32'h0004_0000, 1));
      3: return 31'($urandom_range(32'h0100_0000, 1));
      4: return 31'($urandom_range(32'h0000_0100, 0));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic vbvt_pkg::box_t rand_box();
    vbvt_pkg::box_t b;
    b.box_x = rand_s32();
    b.box_y = rand_s32();
    b.box_width = rand_u31();
    b.box_height = rand_u31();
    return b;
  endfunction

  task automatic random_config();
    write_reg(vbvt_pkg::RegViewMinX, rand_s32());
    write_reg(vbvt_pkg::RegViewMinY, rand_s32());
    write_reg(vbvt_pkg::RegViewW, {1'b0, rand_u31()});
    write_reg(vbvt_pkg::RegViewH, {1'b0, rand_u31()});
    write_reg(vbvt_pkg::RegAlign, $urandom_range(15, 0));
    write_reg(vbvt_pkg::RegSlice, $urandom_range(1, 0));
  endtask

  initial begin
    vbvt_pkg::box_t b;
    view_x = 0; view_y = 0; view_w = 0; view_h = 0;
    align_code = '0; slice_mode = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: no view box, scale one
    box_queue.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h0});
    drain();
    write_reg(vbvt_pkg::RegViewMinX, 32'h8000_0000);
    write_reg(vbvt_pkg::RegViewMinY, 32'h7FFF_FFFF);
    write_reg(vbvt_pkg::RegViewW, 32'h0001_0000);
    write_reg(vbvt_pkg::RegViewH, 32'h7FFF_FFFF);
    write_reg(vbvt_pkg::RegSlice, 32'h1);
    // every alignment code, including undefined ones
    for (int a = 0; a < 16; a++) begin
      write_reg(vbvt_pkg::RegAlign, a);
      b = '{32'sh0010_0000, -32'sh0010_0000, 31'h0020_0000, 31'h0008_0000};
      box_queue.push_back(b);
      box_queue.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF});
      drain();
      if (a == 8) write_reg(vbvt_pkg::RegSlice, 32'h0);
    end
    // one axis absent
    write_reg(vbvt_pkg::RegViewW, 32'h0);
    write_reg(vbvt_pkg::RegViewH, 32'h0003_0000);
    write_reg(vbvt_pkg::RegAlign, 32'd5);
    box_queue.push_back('{32'sh0, 32'sh0, 31'h0001_8000, 31'h0005_0000});
    drain();

    for (int phase = 0; phase < 16; phase++) begin
      random_config();
      if (phase == 3) begin
        hold_req = 1'b1;
        for (int i = 0; i < 150; i++) box_queue.push_back(rand_box());
        drain();
        hold_req = 1'b0;
      end else begin
        for (int i = 0; i < 100; i++) box_queue.push_back(rand_box());
        drain();
      end
    end

    if (mismatches == 0 && expected_xforms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
